[src/svl_pkg.sv]
// Shared types and constants for the sorted value list.
// Used by the controller, the datapath and the top level.
package svl_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_FIELD_W = 7;
  localparam logic [VALUE_W-1:0] EMPTY_SMALLEST = 32'h8000_0001;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef struct packed {
    logic                      func;
    logic signed [VALUE_W-1:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] smallest_value;
    logic                      is_empty;
    logic                      not_found;
    logic                      insert_dropped;
    logic [COUNT_FIELD_W-1:0]  entry_count;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic drop;
    logic rd_prev;
    logic ins_shift;
    logic ins_place;
    logic rd_cur;
    logic rem_step;
    logic rem_done;
    logic rd_head;
    logic cap_head;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pos_zero;
    logic pos_end;
    logic greater;
  } status_t;

endpackage

[src/svl_chan_if.sv]
// Valid/ready channel that carries one word of a given payload type.
// Depends on nothing; the payload type is supplied by each instance.
interface svl_chan_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/svl_ctrl.sv]
// Controller state machine for the sorted value list.
// Depends on svl_pkg; drives datapath commands and reads its status.
module svl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_func,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  input  svl_pkg::status_t sts,
  output svl_pkg::cmd_t    cmd
);
  import svl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_REM_CHK,
    S_REM_CMP,
    S_HEAD_RD,
    S_HEAD_CAP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = (in_func == FUNC_REMOVE) ? S_REM_CHK : S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (sts.full) begin
          cmd.drop = 1'b1;
          state_next = S_HEAD_RD;
        end else if (sts.pos_zero) begin
          cmd.ins_place = 1'b1;
          state_next = S_HEAD_RD;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.greater) begin
          cmd.ins_shift = 1'b1;
          state_next = S_INS_CHK;
        end else begin
          cmd.ins_place = 1'b1;
          state_next = S_HEAD_RD;
        end
      end
      S_REM_CHK: begin
        if (sts.pos_end) begin
          cmd.rem_done = 1'b1;
          state_next = S_HEAD_RD;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        cmd.rem_step = 1'b1;
        state_next = S_REM_CHK;
      end
      S_HEAD_RD: begin
        cmd.rd_head = 1'b1;
        state_next = S_HEAD_CAP;
      end
      S_HEAD_CAP: begin
        cmd.cap_head = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_publish_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result overwritten while still pending");

  a_load_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == S_IDLE))
    else $error("item loaded while busy");

  a_publish_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> (state == S_IDLE) && out_valid)
    else $error("publish did not present a result");

endmodule

[src/svl_datapath.sv]
// Datapath for the sorted value list: entry memory, count, scan position and result.
// Depends on svl_pkg; executes commands from svl_ctrl and returns status.
module svl_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  svl_pkg::in_word_t   in_word,
  input  svl_pkg::cmd_t       cmd,
  output svl_pkg::status_t    sts,
  output svl_pkg::out_word_t  out_word
);
  import svl_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

  logic signed [VALUE_W-1:0] mem [CAPACITY];
  logic signed [VALUE_W-1:0] rdata;
  logic signed [VALUE_W-1:0] value;
  logic signed [VALUE_W-1:0] head;
  logic                      is_remove;
  logic                      found;
  logic                      not_found;
  logic                      dropped;
  logic [CW-1:0]             count;
  logic [CW-1:0]             pos;
  logic [CW-1:0]             pos_dec;
  logic [IW-1:0]             raddr;
  logic [IW-1:0]             waddr;
  logic signed [VALUE_W-1:0] wdata;
  logic                      wen;
  logic                      ren;
  logic [CW+COUNT_FIELD_W-1:0] count_ext;

  assign pos_dec = pos - 1'b1;

  assign sts.full      = (count >= CAP_COUNT);
  assign sts.pos_zero  = (pos == '0);
  assign sts.pos_end   = (pos == count);
  assign sts.greater   = (rdata > value);

  always_comb begin
    ren = cmd.rd_prev || cmd.rd_cur || cmd.rd_head;
    raddr = '0;
    if (cmd.rd_prev) begin
      raddr = pos_dec[IW-1:0];
    end else if (cmd.rd_cur) begin
      raddr = pos[IW-1:0];
    end
    wen = 1'b0;
    waddr = pos[IW-1:0];
    wdata = value;
    if (cmd.ins_shift) begin
      wen = 1'b1;
      wdata = rdata;
    end else if (cmd.ins_place) begin
      wen = 1'b1;
    end else if (cmd.rem_step && found) begin
      wen = 1'b1;
      waddr = pos_dec[IW-1:0];
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_place) begin
      count <= count + 1'b1;
    end else if (cmd.rem_done && found) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= in_word.item_value;
      is_remove <= (in_word.func == FUNC_REMOVE);
      pos <= (in_word.func == FUNC_REMOVE) ? '0 : count;
      found <= 1'b0;
      not_found <= 1'b0;
      dropped <= 1'b0;
    end else begin
      if (cmd.drop) begin
        dropped <= 1'b1;
      end
      if (cmd.ins_shift) begin
        pos <= pos_dec;
      end
      if (cmd.rem_step) begin
        pos <= pos + 1'b1;
        if (!found && (rdata == value)) begin
          found <= 1'b1;
        end
      end
      if (cmd.rem_done && !found) begin
        not_found <= 1'b1;
      end
    end
    if (cmd.cap_head) begin
      head <= (count == '0) ? EMPTY_SMALLEST : rdata;
    end
  end

  assign count_ext = (CW + COUNT_FIELD_W)'(count);

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_word.smallest_value <= head;
      out_word.is_empty       <= (count == '0);
      out_word.not_found      <= not_found;
      out_word.insert_dropped <= dropped;
      out_word.entry_count    <= count_ext[COUNT_FIELD_W-1:0];
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_COUNT)
    else $error("entry count above capacity");

  a_place_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_place |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the count");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    cmd.drop |-> sts.full && !is_remove)
    else $error("insert dropped while space remained");

  a_remove_keeps_pos: assert property (@(posedge clk) disable iff (rst)
    is_remove && !found && !cmd.load |-> pos <= count)
    else $error("remove scan ran past the stored entries");

endmodule

[src/sorted_value_list.sv]
// Sorted value list: a bounded store of signed 32-bit values kept in ascending order,
// duplicates allowed. Each input word inserts a value or removes one occurrence of it, and
// every word yields one result word with the smallest value, empty flag, flags and count.
// Items are handled one at a time by a controller that walks a single-port entry memory
// with a registered read. An insert walks down from the end of the store, shifting each
// greater entry up one place before placing the value, and an insert into a full store
// is refused; a remove scans the whole store, shifting the entries after the match down.
// The store is empty after reset and needs no clearing pass. The input is ready again
// as soon as the result is handed to the output register, and a pending result does
// not block accepting the next word.
// Depends on svl_pkg, svl_chan_if, svl_ctrl and svl_datapath.
module sorted_value_list #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  svl_chan_if.sink    item,
  svl_chan_if.source  result
);
  import svl_pkg::*;

  cmd_t      cmd;
  status_t   sts;
  in_word_t  in_word;
  out_word_t out_word;

  assign in_word = item.data;
  assign result.data = out_word;

  svl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_func   (in_word.func),
    .in_ready  (item.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  svl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule
